// ===== sv/tccw_pkg.sv =====
package tccw_pkg;

  // Default screen geometry and tab width.
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 8;

  // Field widths of the stream payloads.
  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 4;
  localparam int CELL_W  = 16;
  localparam int CFG_IDX_W = 4;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 4'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Content of every cell after reset.
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0700;

endpackage

// ===== sv/text_console_cell_writer.sv =====
// Execution: a put-character, back-stop or read transaction is taken in IDLE, runs on the
// screen memory in EXEC and loads its result into the output register, via DONE if it is held.
// A new item is taken only once the last one is finished; a clear sweeps every cell, and a put
// that passes the last cell scrolls by one or more sweeps that copy each row up (one cell a cycle).
// Reset: synchronous, active high; afterwards a clearing pass fills
// every cell with code 0 and attribute 0x07 while no item is accepted.
module text_console_cell_writer #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic clk,
  input  logic rst,

  // Configuration write channel: register index and data.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccw_pkg::COLOR_W-1:0]     cfg_data,

  // Input items.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: char_code[7:0], back_stop_value[18:8], cell_index[29:19], zero[31:30]
  input  logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata,
  // tuser: kind[1:0]
  input  logic [tccw_pkg::KIND_W-1:0]      s_tuser,

  // Result items.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tdata: cursor_position[10:0], back_stop_position[21:11], scrolled[22],
  //        read_char[30:23], read_attribute[38:31], zero[39]
  output logic [tccw_pkg::M_TDATA_W-1:0]   m_tdata
);

  // Screen geometry. The cursor register is wide enough to hold the position
  // reached by the largest single move past the last cell, before scrolling.
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MAX_STEP   = (COLUMNS > TAB_STEP) ? COLUMNS : TAB_STEP;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CUR_W      = $clog2(CELL_COUNT + MAX_STEP);
  localparam int CW         = $clog2(COLUMNS);
  localparam int PW         = tccw_pkg::POS_W;

  localparam logic [CUR_W-1:0] CELLS_C = CUR_W'(CELL_COUNT);
  localparam logic [CUR_W-1:0] COLS_C  = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] TAB_C   = CUR_W'(TAB_STEP);
  localparam logic [AW-1:0]    SCAN_LAST = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]    COPY_END  = AW'(CELL_COUNT - COLUMNS);
  localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
  localparam logic [CW-1:0]    COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [CW+1:0]    COLS_W2   = (CW+2)'(COLUMNS);
  localparam logic [CW+1:0]    TAB_W2    = (CW+2)'(TAB_STEP);
  localparam logic [PW-1:0]    COLS_P    = PW'(COLUMNS);
  localparam logic [15:0]      CELLS_16  = 16'(CELL_COUNT);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_DONE  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;

  logic [2:0] state;

  // Configuration registers. The channel is always ready; indexes beyond the
  // two color registers are accepted and dropped.
  logic [tccw_pkg::COLOR_W-1:0] fg_color;
  logic [tccw_pkg::COLOR_W-1:0] bg_color;
  logic [7:0]                   attr;

  assign cfg_ready = 1'b1;
  assign attr      = {bg_color, fg_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tccw_pkg::FG_RESET;
      bg_color <= tccw_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tccw_pkg::CFG_FOREGROUND) begin
        fg_color <= cfg_data;
      end
      if (cfg_index == tccw_pkg::CFG_BACKGROUND) begin
        bg_color <= cfg_data;
      end
    end
  end

  // Screen memory: one write and one registered read per cycle.
  logic [tccw_pkg::CELL_W-1:0] mem [CELL_COUNT];
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [tccw_pkg::CELL_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [tccw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Console state.
  logic [CUR_W-1:0] cursor;
  logic [CW-1:0]    col;        // cursor column, kept so newline needs no modulo
  logic [PW-1:0]    back_stop;
  logic             scrolled;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;

  // The item under execution.
  logic [tccw_pkg::KIND_W-1:0] item_kind;
  logic [7:0]                  item_code;
  logic [PW-1:0]               item_stop;
  logic                        item_rd_ok;

  // Sweep engine used by reset fill, clear and scroll. An issue stage walks scan over
  // every cell; in copy mode it reads the cell one row below, except on the last row.
  // A write stage in the next cycle stores either that read data or fill_word.
  logic [AW-1:0]               scan;
  logic                        sweep_copy;
  logic                        sweep_init;
  logic [tccw_pkg::CELL_W-1:0] fill_word;
  logic                        wp_valid;
  logic [AW-1:0]               wp_addr;
  logic                        wp_mem;

  // Field extraction from the input stream.
  logic [7:0]    in_code;
  logic [PW-1:0] in_stop;
  logic [PW-1:0] in_index;
  logic [AW+PW-1:0] in_index_wide;

  assign in_code  = s_tdata[7:0];
  assign in_stop  = s_tdata[18:8];
  assign in_index = s_tdata[29:19];
  assign in_index_wide = {{AW{1'b0}}, in_index};

  // An item is taken only in IDLE and only once the last sweep write has
  // landed, so its read never meets a pending write.
  assign s_tready = (state == ST_IDLE) && !wp_valid;

  logic s_take;
  assign s_take = s_tvalid && s_tready;

  // The output register may be loaded when it is empty or being emptied.
  logic can_load;
  assign can_load = !m_tvalid || m_tready;

  // Column arithmetic for put and tab.
  logic [CW+1:0] col_t0;
  logic [CW+1:0] col_t1;
  logic [CW+1:0] col_t2;
  logic [CW-1:0] col_tab;
  logic [CW-1:0] col_inc;
  logic [CW-1:0] col_dec;

  always_comb begin
    col_t0  = {2'b00, col} + TAB_W2;
    col_t1  = (col_t0 >= COLS_W2) ? col_t0 - COLS_W2 : col_t0;
    col_t2  = (col_t1 >= COLS_W2) ? col_t1 - COLS_W2 : col_t1;
    col_tab = col_t2[CW-1:0];
    col_inc = (col == COL_LAST) ? '0 : col + 1'b1;
    col_dec = (col == '0) ? COL_LAST : col - 1'b1;
  end

  // Execute stage: the effect of one item on cursor, back-stop and screen.
  logic [CUR_W-1:0]       cursor_next;
  logic [CW-1:0]          col_next;
  logic [PW-1:0]          back_stop_next;
  logic                   scrolled_next;
  logic [7:0]             res_char_next;
  logic [7:0]             res_attr_next;
  logic                   exec_we;
  logic [AW-1:0]          exec_waddr;
  logic [tccw_pkg::CELL_W-1:0] exec_wdata;
  logic [CUR_W+PW-1:0]    cur_cmp;
  logic [CUR_W+PW-1:0]    stop_cmp;
  logic [CUR_W-1:0]       cursor_dec;

  assign cur_cmp    = {{PW{1'b0}}, cursor};
  assign stop_cmp   = {{CUR_W{1'b0}}, back_stop};
  assign cursor_dec = cursor - 1'b1;

  always_comb begin
    cursor_next    = cursor;
    col_next       = col;
    back_stop_next = back_stop;
    scrolled_next  = scrolled;
    res_char_next  = res_char;
    res_attr_next  = res_attr;
    exec_we        = 1'b0;
    exec_waddr     = cursor[AW-1:0];
    exec_wdata     = {attr, item_code};
    if (state == ST_EXEC) begin
      scrolled_next = 1'b0;
      res_char_next = '0;
      res_attr_next = '0;
      unique case (item_kind)
        tccw_pkg::KIND_PUT: begin
          priority if (item_code == tccw_pkg::CH_BACKSPACE) begin
            // Backspace only moves while the cursor is beyond the back-stop.
            if (cur_cmp > stop_cmp) begin
              cursor_next = cursor_dec;
              col_next    = col_dec;
              exec_we     = 1'b1;
              exec_waddr  = cursor_dec[AW-1:0];
              exec_wdata  = {attr, 8'h00};
            end
          end else if (item_code == tccw_pkg::CH_TAB) begin
            cursor_next = cursor + TAB_C;
            col_next    = col_tab;
          end else if (item_code == tccw_pkg::CH_NEWLINE) begin
            cursor_next = cursor + (COLS_C - CUR_W'(col));
            col_next    = '0;
          end else begin
            cursor_next = cursor + 1'b1;
            col_next    = col_inc;
            exec_we     = 1'b1;
          end
        end
        tccw_pkg::KIND_CLEAR: begin
          cursor_next    = '0;
          col_next       = '0;
          back_stop_next = '0;
        end
        tccw_pkg::KIND_STOP: begin
          back_stop_next = item_stop;
        end
        tccw_pkg::KIND_READ: begin
          if (item_rd_ok) begin
            res_char_next = mem_rdata[7:0];
            res_attr_next = mem_rdata[15:8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A put that moves the cursor past the last cell needs a scroll before its
  // result can go out.
  logic exec_direct;
  assign exec_direct = (state == ST_EXEC) && can_load && (cursor_next < CELLS_C) &&
                       (item_kind != tccw_pkg::KIND_CLEAR);

  logic done_scroll;
  logic done_load;
  assign done_scroll = (state == ST_DONE) && (cursor >= CELLS_C);
  assign done_load   = (state == ST_DONE) && !done_scroll && can_load;

  // Memory port selection. Writes from the sweep and from the execute stage
  // never fall in the same cycle.
  logic sweep_rd;
  assign sweep_rd = (state == ST_SWEEP) && sweep_copy && (scan < COPY_END);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = exec_waddr;
    mem_wdata = exec_wdata;
    if (wp_valid) begin
      mem_we    = 1'b1;
      mem_waddr = wp_addr;
      mem_wdata = wp_mem ? mem_rdata : fill_word;
    end else if (exec_we) begin
      mem_we = 1'b1;
    end
    mem_re    = 1'b0;
    mem_raddr = in_index_wide[AW-1:0];
    if (sweep_rd) begin
      mem_re    = 1'b1;
      mem_raddr = scan + COLS_A;
    end else if (s_take && (s_tuser == tccw_pkg::KIND_READ)) begin
      mem_re = 1'b1;
    end
  end

  // Back-stop after one scroll drops a row and saturates at zero.
  logic [PW-1:0] stop_scrolled;
  assign stop_scrolled = (back_stop >= COLS_P) ? back_stop - COLS_P : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      scan       <= '0;
      sweep_copy <= 1'b0;
      sweep_init <= 1'b1;
      fill_word  <= tccw_pkg::RESET_CELL;
      wp_valid   <= 1'b0;
      cursor     <= '0;
      col        <= '0;
      back_stop  <= '0;
      scrolled   <= 1'b0;
      res_char   <= '0;
      res_attr   <= '0;
    end else begin
      wp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_take) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cursor    <= cursor_next;
          col       <= col_next;
          back_stop <= back_stop_next;
          scrolled  <= scrolled_next;
          res_char  <= res_char_next;
          res_attr  <= res_attr_next;
          if (item_kind == tccw_pkg::KIND_CLEAR) begin
            scan       <= '0;
            sweep_copy <= 1'b0;
            sweep_init <= 1'b0;
            fill_word  <= {attr, 8'h00};
            state      <= ST_SWEEP;
          end else if (exec_direct) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_scroll) begin
            cursor     <= cursor - COLS_C;
            back_stop  <= stop_scrolled;
            scrolled   <= 1'b1;
            scan       <= '0;
            sweep_copy <= 1'b1;
            sweep_init <= 1'b0;
            fill_word  <= {attr, 8'h00};
            state      <= ST_SWEEP;
          end else if (done_load) begin
            state <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          wp_valid <= 1'b1;
          wp_addr  <= scan;
          wp_mem   <= sweep_rd;
          if (scan == SCAN_LAST) begin
            state <= sweep_init ? ST_IDLE : ST_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture; the range check of a read is done here.
  always_ff @(posedge clk) begin
    if (s_take) begin
      item_kind  <= s_tuser;
      item_code  <= in_code;
      item_stop  <= in_stop;
      item_rd_ok <= {5'd0, in_index} < CELLS_16;
    end
  end

  // Output register.
  logic [CUR_W+PW-1:0] cur_wide;
  logic                out_load;

  assign cur_wide = {{PW{1'b0}}, cursor_next};
  assign out_load = exec_direct || done_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_attr_next, res_char_next, scrolled_next, back_stop_next,
                  cur_wide[PW-1:0]};
    end
  end

  // Checks.
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cursor < CELLS_C))
    else $error("cursor left the screen outside a scroll");

  a_no_rw_same_cell: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("screen memory read and write hit the same cell");

  a_write_port_free: assert property (@(posedge clk) disable iff (rst)
    wp_valid |-> !exec_we)
    else $error("sweep write collided with an item write");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EXEC || $past(state) == ST_DONE))
    else $error("result appeared outside execute or done");

endmodule

// ===== test/text_console_cell_writer_checker.sv =====
`timescale 1ns / 1ps

module text_console_cell_writer_checker #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // tdata: char_code[7:0], back_stop_value[18:8], cell_index[29:19], zero[31:30]
  input  logic [tccw_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: kind[1:0]
  input  logic [tccw_pkg::KIND_W-1:0]    s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata: cursor_position[10:0], back_stop_position[21:11], scrolled[22],
  //        read_char[30:23], read_attribute[38:31], zero[39]
  input  logic [tccw_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             mismatch_count,
  output int                             pending_results
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [tccw_pkg::POS_W-1:0]  cursor_now;
    logic [tccw_pkg::POS_W-1:0]  stop_now;
    logic                        scrolled;
    logic [tccw_pkg::CHAR_W-1:0] rd_char;
    logic [tccw_pkg::CHAR_W-1:0] rd_attr;
  } console_result_t;

  // Shadow copy of the console state.
  logic [tccw_pkg::CELL_W-1:0]  shadow_screen [CELLS];
  int unsigned                  shadow_cursor;
  int unsigned                  shadow_back_stop;
  logic [tccw_pkg::COLOR_W-1:0] shadow_fg;
  logic [tccw_pkg::COLOR_W-1:0] shadow_bg;

  console_result_t expected_results [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task reset_console();
    for (int i = 0; i < CELLS; i++) begin
      shadow_screen[i] = tccw_pkg::RESET_CELL;
    end
    shadow_cursor    = 0;
    shadow_back_stop = 0;
    shadow_fg        = tccw_pkg::FG_RESET;
    shadow_bg        = tccw_pkg::BG_RESET;
    expected_results.delete();
  endtask

  task write_cell(input int unsigned pos, input logic [tccw_pkg::CHAR_W-1:0] code);
    if (pos < CELLS) begin
      shadow_screen[pos] = {shadow_bg, shadow_fg, code};
    end
  endtask

  task scroll_console();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      shadow_screen[i] = shadow_screen[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      shadow_screen[i] = {shadow_bg, shadow_fg, 8'h00};
    end
    shadow_cursor    = shadow_cursor - COLUMNS;
    shadow_back_stop = (shadow_back_stop >= COLUMNS) ? shadow_back_stop - COLUMNS : 0;
  endtask

  task predict_console_step(input logic [tccw_pkg::KIND_W-1:0] kind,
                            input logic [tccw_pkg::CHAR_W-1:0] code,
                            input logic [tccw_pkg::POS_W-1:0] stop_value,
                            input logic [tccw_pkg::POS_W-1:0] cell_idx);
    console_result_t res;
    res = '0;
    case (kind)
      tccw_pkg::KIND_PUT: begin
        if (code == tccw_pkg::CH_BACKSPACE) begin
          if (shadow_cursor > shadow_back_stop) begin
            shadow_cursor--;
            write_cell(shadow_cursor, 8'h00);
          end
        end else if (code == tccw_pkg::CH_TAB) begin
          shadow_cursor += TAB_STEP;
        end else if (code == tccw_pkg::CH_NEWLINE) begin
          shadow_cursor += COLUMNS - (shadow_cursor % COLUMNS);
        end else begin
          write_cell(shadow_cursor, code);
          shadow_cursor++;
        end
        while (shadow_cursor >= CELLS) begin
          scroll_console();
          res.scrolled = 1'b1;
        end
      end
      tccw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_screen[i] = {shadow_bg, shadow_fg, 8'h00};
        end
        shadow_cursor    = 0;
        shadow_back_stop = 0;
      end
      tccw_pkg::KIND_STOP: begin
        shadow_back_stop = 32'(stop_value);
      end
      default: begin
        if (cell_idx < CELLS) begin
          res.rd_char = shadow_screen[cell_idx][7:0];
          res.rd_attr = shadow_screen[cell_idx][15:8];
        end
      end
    endcase
    res.cursor_now = shadow_cursor[tccw_pkg::POS_W-1:0];
    res.stop_now   = shadow_back_stop[tccw_pkg::POS_W-1:0];
    expected_results.push_back(res);
  endtask

  task compare_result(input logic [tccw_pkg::M_TDATA_W-1:0] data);
    console_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result transaction", int'(data[21:0]), -1);
    end else begin
      want = expected_results.pop_front();
      if (data[10:0] !== want.cursor_now)
        report_mismatch("cursor_position", int'(data[10:0]), int'(want.cursor_now));
      if (data[21:11] !== want.stop_now)
        report_mismatch("back_stop_position", int'(data[21:11]), int'(want.stop_now));
      if (data[22] !== want.scrolled)
        report_mismatch("scrolled", int'(data[22]), int'(want.scrolled));
      if (data[30:23] !== want.rd_char)
        report_mismatch("read_char", int'(data[30:23]), int'(want.rd_char));
      if (data[38:31] !== want.rd_attr)
        report_mismatch("read_attribute", int'(data[38:31]), int'(want.rd_attr));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_console();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tccw_pkg::CFG_FOREGROUND) begin
          shadow_fg = cfg_data;
        end else if (cfg_index == tccw_pkg::CFG_BACKGROUND) begin
          shadow_bg = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_console_step(s_tuser, s_tdata[7:0], s_tdata[18:8], s_tdata[29:19]);
      end
      if (m_tvalid && m_tready) begin
        compare_result(m_tdata);
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== test/text_console_cell_writer_tb.sv =====
`timescale 1ns / 1ps

module text_console_cell_writer_tb;

  // The run is far shorter than this; the bound assumes every item is a clear
  // or a scroll and every transaction waits out the longest stalls, then adds margin.
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RANDOM_ITEMS_PER_PHASE = 177;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tccw_pkg::COLOR_W-1:0]     cfg_data  = '0;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [tccw_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
  logic [tccw_pkg::KIND_W-1:0]      s_tuser   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [tccw_pkg::M_TDATA_W-1:0]   m_tdata;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;

  // Idle percentages for the sender and the receiver, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Cursor seen in the most recent result. It lags the block by the items
  // in flight, which is good enough to aim reads and back-stops near it.
  int last_cursor = 0;

  text_console_cell_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  text_console_cell_writer_checker console_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // 2 ns clock period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cell_writer test failed");
      $finish;
    end
  end

  // The receiver drops tready at random; one decision per falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      last_cursor <= int'(m_tdata[10:0]);
    end
  end

  // One configuration transaction. Only called while nothing is in flight.
  task automatic write_register(input logic [tccw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tccw_pkg::COLOR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One input transaction, preceded by a random number of idle cycles. The
  // valid stays high after acceptance so that back-to-back items are possible;
  // the caller lowers it once the stimulus of a phase is done.
  task automatic send_item(input logic [tccw_pkg::KIND_W-1:0] kind,
                           input logic [tccw_pkg::CHAR_W-1:0] code,
                           input int stop_value, input int cell_idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, cell_idx[tccw_pkg::POS_W-1:0], stop_value[tccw_pkg::POS_W-1:0], code};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Wait until every predicted result has come back, then let the block
  // settle before registers are touched again.
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int near_cursor(input int max_back);
    int back;
    back = $urandom_range(0, max_back);
    return (last_cursor > back) ? last_cursor - back : 0;
  endfunction

  // Random console traffic. Most items are character writes, with enough
  // newlines and tabs to push the cursor to the bottom and keep it scrolling;
  // back-stops and reads are aimed near the cursor half of the time so that
  // backspace and read-back meet cells that were actually written.
  task automatic send_random_item();
    int roll;
    int sel;
    int stop_value;
    int cell_idx;
    logic [tccw_pkg::CHAR_W-1:0] code;
    roll       = $urandom_range(0, 999);
    sel        = $urandom_range(0, 99);
    code       = 8'($urandom_range(0, 255));
    stop_value = $urandom_range(0, 2047);
    cell_idx   = $urandom_range(0, 2047);
    if (roll < 10) begin
      send_item(tccw_pkg::KIND_CLEAR, code, stop_value, cell_idx);
    end else if (roll < 70) begin
      if (sel < 50) begin
        stop_value = near_cursor(40);
      end else if (sel < 75) begin
        stop_value = 0;
      end
      send_item(tccw_pkg::KIND_STOP, code, stop_value, cell_idx);
    end else if (roll < 200) begin
      if (sel < 50) begin
        cell_idx = near_cursor(160);
      end
      send_item(tccw_pkg::KIND_READ, code, stop_value, cell_idx);
    end else begin
      if (sel < 16) begin
        code = tccw_pkg::CH_NEWLINE;
      end else if (sel < 30) begin
        code = tccw_pkg::CH_BACKSPACE;
      end else if (sel < 38) begin
        code = tccw_pkg::CH_TAB;
      end
      send_item(tccw_pkg::KIND_PUT, code, stop_value, cell_idx);
    end
  endtask

  task automatic random_phase(input int sender_idle, input int receiver_idle);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (RANDOM_ITEMS_PER_PHASE) send_random_item();
    stop_sending();
    wait_for_drain();
  endtask

  initial begin
    // Synchronous reset; the block then runs its own
    // clearing pass, during which it holds tready low.
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the reset colors in effect.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    // Read-back of the reset screen, including cells just past the end
    // and the top of the index field, which must read as zero.
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 0);
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 1999);
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 2000);
    send_item(tccw_pkg::KIND_READ, 8'hFF, 2047, 2047);
    // Backspace with the cursor sitting on the back-stop does nothing.
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_BACKSPACE, $urandom_range(0, 2047),
              $urandom_range(0, 2047));
    // Printable extremes: code 0 is printed like any other.
    send_item(tccw_pkg::KIND_PUT, 8'h41, $urandom_range(0, 2047), $urandom_range(0, 2047));
    send_item(tccw_pkg::KIND_PUT, 8'hFF, $urandom_range(0, 2047), $urandom_range(0, 2047));
    send_item(tccw_pkg::KIND_PUT, 8'h00, $urandom_range(0, 2047), $urandom_range(0, 2047));
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 0);
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 1);
    // Backspace beyond the back-stop steps back and blanks the cell.
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_BACKSPACE, 0, 0);
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 2);
    // Tab moves without writing, newline goes to the next row start.
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_TAB, 0, 0);
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_NEWLINE, 0, 0);
    // Back-stop at the cursor blocks backspace.
    send_item(tccw_pkg::KIND_STOP, 8'h00, 80, 0);
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_BACKSPACE, 0, 0);
    send_item(tccw_pkg::KIND_PUT, 8'h5A, 0, 0);
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_BACKSPACE, 0, 0);
    // A back-stop beyond the screen is kept as given and makes backspace inert.
    send_item(tccw_pkg::KIND_STOP, 8'h00, 2047, 0);
    send_item(tccw_pkg::KIND_PUT, tccw_pkg::CH_BACKSPACE, 0, 0);
    send_item(tccw_pkg::KIND_STOP, 8'h00, 1999, 0);
    send_item(tccw_pkg::KIND_STOP, 8'h00, 0, 0);
    // Clear blanks the screen and homes cursor and back-stop.
    send_item(tccw_pkg::KIND_CLEAR, 8'h00, 0, 0);
    send_item(tccw_pkg::KIND_READ, 8'h00, 0, 0);
    stop_sending();
    wait_for_drain();

    // Brightest colors, plus a write to an unused index that must be ignored.
    write_register(tccw_pkg::CFG_FOREGROUND, 4'hF);
    write_register(tccw_pkg::CFG_BACKGROUND, 4'hF);
    write_register(4'hF, 4'h0);
    random_phase(16, 83);

    // All-zero colors, and another ignored index.
    write_register(tccw_pkg::CFG_FOREGROUND, 4'h0);
    write_register(tccw_pkg::CFG_BACKGROUND, 4'h0);
    write_register(4'h6, 4'hA);
    random_phase(83, 16);

    write_register(tccw_pkg::CFG_FOREGROUND, 4'($urandom_range(0, 15)));
    write_register(tccw_pkg::CFG_BACKGROUND, 4'($urandom_range(0, 15)));
    random_phase(0, 0);

    // Let the block settle after the last result before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_cell_writer test passed");
    end else begin
      $display("text_console_cell_writer test failed");
    end
    $finish;
  end

endmodule
